### design/aeh_pkg.sv
package aeh_pkg;

  // configuration register indexes
  localparam logic [0:0] CFG_ENERGY_SCALE  = 1'd0;
  localparam logic [0:0] CFG_ENERGY_CUTOFF = 1'd1;

  localparam logic [31:0] ENERGY_SCALE_RST  = 32'd131;
  localparam logic [31:0] ENERGY_CUTOFF_RST = 32'd256;

  localparam logic [0:0] OP_PARTICLE = 1'd0;
  localparam logic [0:0] OP_READ     = 1'd1;

  localparam logic [47:0] E_MAX = 48'hFFFF_FFFF_FFFF;

  // azimuth in units of 2^-32 turn
  localparam int CORDIC_STEPS = 30;
  localparam logic signed [33:0] QUARTER_TURN = 34'sd1073741824;
  localparam logic signed [33:0] HALF_TURN    = 34'sd2147483648;

  localparam logic [29:0] ATAN_TURNS [CORDIC_STEPS] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10680862, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722,
    30'd20861, 30'd10430, 30'd5215, 30'd2608, 30'd1304,
    30'd652, 30'd326, 30'd163, 30'd81, 30'd41,
    30'd20, 30'd10, 30'd5, 30'd3, 30'd1
  };

  typedef enum logic [4:0] {
    S_IDLE,
    S_SQ_X,
    S_SQ_Y,
    S_SQ_Z,
    S_SQ_ADD,
    S_ROOT1,
    S_DIV1,
    S_EK_LO,
    S_EK_HI,
    S_EK_FIN,
    S_CHECK,
    S_ROOT2,
    S_DIV2,
    S_ANGLE,
    S_CW_LO,
    S_CW_HI,
    S_CW_FIN,
    S_HRD,
    S_HWR,
    S_RD,
    S_RCAP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } hist_ctl_t;

  // saturating 64 bit add
  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
  endfunction

endpackage

### design/aeh_in_if.sv
interface aeh_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [31:0] mom_x;
  logic signed [31:0] mom_y;
  logic signed [31:0] mom_z;
  logic [31:0]        weight;
  logic [5:0]         read_theta;
  logic [5:0]         read_phi;

  modport source(output valid, opcode, mom_x, mom_y, mom_z, weight, read_theta, read_phi,
                 input ready);
  modport sink(input valid, opcode, mom_x, mom_y, mom_z, weight, read_theta, read_phi,
               output ready);
endinterface

### design/aeh_out_if.sv
interface aeh_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [5:0]  theta_bin;
  logic [5:0]  phi_bin;
  logic [47:0] kinetic_energy;
  logic [63:0] bin_value;
  logic [63:0] total_energy;
  logic [63:0] total_count;

  modport source(output valid, accepted, theta_bin, phi_bin, kinetic_energy, bin_value,
                 total_energy, total_count, input ready);
  modport sink(input valid, accepted, theta_bin, phi_bin, kinetic_energy, bin_value,
               total_energy, total_count, output ready);
endinterface

### design/aeh_sqrt.sv
module aeh_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [63:0] operand,
  output logic        done,
  output logic [63:0] root
);

  logic [63:0] v_r, res_r, bit_r;
  logic [4:0]  cnt_r;
  logic        busy_r, done_r;
  logic [64:0] trial;

  assign trial = {1'b0, res_r} + {1'b0, bit_r};
  assign done  = done_r;
  assign root  = res_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // two bits of the radicand per step
  always_ff @(posedge clk) begin
    if (go) begin
      v_r   <= operand;
      res_r <= '0;
      bit_r <= 64'h4000_0000_0000_0000;
    end else if (busy_r) begin
      if ({1'b0, v_r} >= trial) begin
        v_r   <= v_r - trial[63:0];
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

endmodule

### design/aeh_div.sv
module aeh_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic [63:0] rem_r, quo_r, den_r;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r;
  logic [64:0] shifted;

  assign shifted  = {rem_r, quo_r[63]};
  assign done     = done_r;
  assign quotient = quo_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // restoring division, one quotient bit per step
  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= '0;
      quo_r <= dividend;
      den_r <= divisor;
    end else if (busy_r) begin
      if (shifted >= {1'b0, den_r}) begin
        rem_r <= 64'(shifted - {1'b0, den_r});
        quo_r <= {quo_r[62:0], 1'b1};
      end else begin
        rem_r <= shifted[63:0];
        quo_r <= {quo_r[62:0], 1'b0};
      end
    end
  end

endmodule

### design/aeh_cordic.sv
module aeh_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic signed [31:0] uy,
  input  logic signed [31:0] uz,
  output logic               done,
  output logic [32:0]        phase
);

  logic signed [35:0] x_r, y_r;
  logic signed [33:0] z_r;
  logic [4:0]         cnt_r;
  logic               busy_r, done_r, neg_r, zero_r;
  logic signed [35:0] dx, dy, ay;
  logic signed [33:0] atan_s, zc, ang;

  assign ay     = uy[31] ? -36'(uy) : 36'(uy);
  assign dx     = y_r >>> cnt_r;
  assign dy     = x_r >>> cnt_r;
  assign atan_s = 34'(aeh_pkg::ATAN_TURNS[cnt_r]);
  assign done   = done_r;

  // clamp to half turn, mirror for negative y
  always_comb begin
    if (z_r < 34'sd0) begin
      zc = '0;
    end else if (z_r > aeh_pkg::HALF_TURN) begin
      zc = aeh_pkg::HALF_TURN;
    end else begin
      zc = z_r;
    end
    if (zero_r) begin
      ang = '0;
    end else if (neg_r) begin
      ang = -zc;
    end else begin
      ang = zc;
    end
    phase = 33'(ang + aeh_pkg::HALF_TURN);
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(aeh_pkg::CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // vectoring steps, left half plane turned by a quarter first
  always_ff @(posedge clk) begin
    if (go) begin
      neg_r  <= uy[31];
      zero_r <= (uy == 32'sd0) && (uz == 32'sd0);
      if (uz[31]) begin
        x_r <= ay;
        y_r <= -36'(uz);
        z_r <= aeh_pkg::QUARTER_TURN;
      end else begin
        x_r <= 36'(uz);
        y_r <= ay;
        z_r <= '0;
      end
    end else if (busy_r) begin
      if (y_r >= 36'sd0) begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + atan_s;
      end else begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - atan_s;
      end
    end
  end

endmodule

### design/aeh_hist.sv
module aeh_hist #(
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  aeh_pkg::hist_ctl_t       ctl,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [63:0]              wdata,
  output logic [63:0]              rdata,
  output logic                     busy
);

  localparam int AW = $clog2(DEPTH);

  logic [63:0]   mem [DEPTH];
  logic [AW-1:0] clr_addr_r;
  logic          clr_r;

  assign busy = clr_r;

  // clearing sweep after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  // single port storage, registered read
  always_ff @(posedge clk) begin
    if (clr_r) begin
      mem[clr_addr_r] <= '0;
    end else if (ctl.wr_en) begin
      mem[addr] <= wdata;
    end
    if (ctl.rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

### design/angular_energy_histogram_top.sv
// Angular energy histogram. Each input word is either a particle (opcode 0) or a bin
// readout (opcode 1); each gives one result word. A particle runs through a sequencer
// sharing one 32x32 multiplier, a 2-bit-per-step square root (32 steps, used twice), a
// 1-bit-per-step divider (64 steps, used twice) and a 30-step CORDIC; a rejected particle
// skips the second root, the second division and the CORDIC. The bins live in one
// single-port memory read, updated and written back in sequence. After reset the memory
// is cleared, one bin per cycle, before the first word is taken; configuration writes
// are taken at any time.
module angular_energy_histogram_top #(
  parameter int THETA_BINS = 64,
  parameter int PHI_BINS   = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  aeh_in_if.sink      in_ch,
  aeh_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int HDEPTH = THETA_BINS * PHI_BINS;
  localparam int HAW    = $clog2(HDEPTH);
  localparam int TW     = $clog2(THETA_BINS);
  localparam int PW     = $clog2(PHI_BINS);

  aeh_pkg::state_t    state_r, state_nxt;
  aeh_pkg::hist_ctl_t hctl;

  logic [31:0]        scale_r, cutoff_r;
  logic               op_r;
  logic signed [31:0] ux_r, uy_r, uz_r;
  logic [31:0]        w_r;
  logic [5:0]         rt_r, rp_r;
  logic [63:0]        u2_r, d_r, r_r, lo_r, prod_r, contrib_r, bin_r;
  logic [32:0]        m_r;
  logic [47:0]        ek_r;
  logic [TW-1:0]      tbin_r;
  logic [PW-1:0]      pbin_r;
  logic               acc_r, launched_r;
  logic [63:0]        esum_r, count_r;

  logic               out_valid_r, out_acc_r;
  logic [5:0]         out_theta_r, out_phi_r;
  logic [47:0]        out_ek_r;
  logic [63:0]        out_bin_r, out_esum_r, out_count_r;

  logic               in_fire, rd_in_range, out_free, accept;
  logic [31:0]        mul_a, mul_b;
  logic               sq_go, sq_done, dv_go, dv_done, cd_go, cd_done;
  logic [63:0]        sq_in, sq_root, dv_num, dv_den, dv_quo;
  logic [32:0]        phase;
  logic [HAW-1:0]     haddr;
  logic [63:0]        hwdata, hrdata;
  logic               hbusy;
  logic [95:0]        ek_full;
  logic [63:0]        diff;
  logic [43:0]        pprod;
  logic [11:0]        pq;

  assign in_fire     = in_ch.valid && in_ch.ready;
  assign rd_in_range = (32'(in_ch.read_theta) < THETA_BINS) && (32'(in_ch.read_phi) < PHI_BINS);
  assign out_free    = !out_valid_r || out_ch.ready;
  assign accept      = (u2_r != 64'd0) && (ek_r >= 48'(cutoff_r));
  assign ek_full     = {32'd0, lo_r} + {prod_r, 32'd0};
  assign diff        = 64'(m_r) - 64'(ux_r);
  assign pprod       = 44'(phase) * 44'(PHI_BINS);
  assign pq          = pprod[43:32];

  // iterative units; the root and the divider are each used twice
  aeh_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .go(sq_go), .operand(sq_in), .done(sq_done), .root(sq_root)
  );

  aeh_div u_div (
    .clk(clk), .rst_n(rst_n), .go(dv_go), .dividend(dv_num), .divisor(dv_den),
    .done(dv_done), .quotient(dv_quo)
  );

  aeh_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .go(cd_go), .uy(uy_r), .uz(uz_r), .done(cd_done), .phase(phase)
  );

  aeh_hist #(.DEPTH(HDEPTH)) u_hist (
    .clk(clk), .rst_n(rst_n), .ctl(hctl), .addr(haddr), .wdata(hwdata), .rdata(hrdata),
    .busy(hbusy)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      aeh_pkg::S_IDLE: begin
        if (in_fire) begin
          if (in_ch.opcode == aeh_pkg::OP_READ) begin
            state_nxt = rd_in_range ? aeh_pkg::S_RD : aeh_pkg::S_DONE;
          end else begin
            state_nxt = aeh_pkg::S_SQ_X;
          end
        end
      end
      aeh_pkg::S_SQ_X:   state_nxt = aeh_pkg::S_SQ_Y;
      aeh_pkg::S_SQ_Y:   state_nxt = aeh_pkg::S_SQ_Z;
      aeh_pkg::S_SQ_Z:   state_nxt = aeh_pkg::S_SQ_ADD;
      aeh_pkg::S_SQ_ADD: state_nxt = aeh_pkg::S_ROOT1;
      aeh_pkg::S_ROOT1:  if (sq_done) state_nxt = aeh_pkg::S_DIV1;
      aeh_pkg::S_DIV1:   if (dv_done) state_nxt = aeh_pkg::S_EK_LO;
      aeh_pkg::S_EK_LO:  state_nxt = aeh_pkg::S_EK_HI;
      aeh_pkg::S_EK_HI:  state_nxt = aeh_pkg::S_EK_FIN;
      aeh_pkg::S_EK_FIN: state_nxt = aeh_pkg::S_CHECK;
      aeh_pkg::S_CHECK:  state_nxt = accept ? aeh_pkg::S_ROOT2 : aeh_pkg::S_DONE;
      aeh_pkg::S_ROOT2:  if (sq_done) state_nxt = aeh_pkg::S_DIV2;
      aeh_pkg::S_DIV2:   if (dv_done) state_nxt = aeh_pkg::S_ANGLE;
      aeh_pkg::S_ANGLE:  if (cd_done) state_nxt = aeh_pkg::S_CW_LO;
      aeh_pkg::S_CW_LO:  state_nxt = aeh_pkg::S_CW_HI;
      aeh_pkg::S_CW_HI:  state_nxt = aeh_pkg::S_CW_FIN;
      aeh_pkg::S_CW_FIN: state_nxt = aeh_pkg::S_HRD;
      aeh_pkg::S_HRD:    state_nxt = aeh_pkg::S_HWR;
      aeh_pkg::S_HWR:    state_nxt = aeh_pkg::S_DONE;
      aeh_pkg::S_RD:     state_nxt = aeh_pkg::S_RCAP;
      aeh_pkg::S_RCAP:   state_nxt = aeh_pkg::S_DONE;
      aeh_pkg::S_DONE:   if (out_free) state_nxt = aeh_pkg::S_IDLE;
      default:           state_nxt = aeh_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ch.ready = 1'b0;
    sq_go       = 1'b0;
    dv_go       = 1'b0;
    cd_go       = 1'b0;
    sq_in       = u2_r;
    dv_num      = u2_r;
    dv_den      = d_r;
    mul_a       = '0;
    mul_b       = '0;
    hctl        = '0;
    haddr       = HAW'(32'(tbin_r) * PHI_BINS + 32'(pbin_r));
    hwdata      = aeh_pkg::sat_add(hrdata, contrib_r);
    unique case (state_r)
      aeh_pkg::S_IDLE:   in_ch.ready = !hbusy;
      aeh_pkg::S_SQ_X:   mul_a = ux_r[31] ? (~ux_r + 32'd1) : ux_r;
      aeh_pkg::S_SQ_Y:   mul_a = uy_r[31] ? (~uy_r + 32'd1) : uy_r;
      aeh_pkg::S_SQ_Z:   mul_a = uz_r[31] ? (~uz_r + 32'd1) : uz_r;
      aeh_pkg::S_ROOT1: begin
        sq_go = !launched_r;
        sq_in = u2_r + 64'h1_0000_0000;
      end
      aeh_pkg::S_DIV1:   dv_go = !launched_r;
      aeh_pkg::S_EK_LO: begin
        mul_a = scale_r;
        mul_b = r_r[31:0];
      end
      aeh_pkg::S_EK_HI: begin
        mul_a = scale_r;
        mul_b = r_r[63:32];
      end
      aeh_pkg::S_ROOT2:  sq_go = !launched_r;
      aeh_pkg::S_DIV2: begin
        dv_go  = !launched_r;
        dv_num = 64'(diff[33:0]) * 64'(THETA_BINS);
        dv_den = {30'd0, m_r, 1'b0};
      end
      aeh_pkg::S_ANGLE:  cd_go = !launched_r;
      aeh_pkg::S_CW_LO: begin
        mul_a = w_r;
        mul_b = ek_r[31:0];
      end
      aeh_pkg::S_CW_HI: begin
        mul_a = w_r;
        mul_b = {16'd0, ek_r[47:32]};
      end
      aeh_pkg::S_HRD:    hctl.rd_en = 1'b1;
      aeh_pkg::S_HWR:    hctl.wr_en = 1'b1;
      aeh_pkg::S_RD: begin
        hctl.rd_en = 1'b1;
        haddr      = HAW'(32'(rt_r) * PHI_BINS + 32'(rp_r));
      end
      default: begin
      end
    endcase
    if (state_r == aeh_pkg::S_SQ_X || state_r == aeh_pkg::S_SQ_Y ||
        state_r == aeh_pkg::S_SQ_Z) begin
      mul_b = mul_a;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aeh_pkg::S_IDLE;
      launched_r  <= 1'b0;
      out_valid_r <= 1'b0;
      scale_r     <= aeh_pkg::ENERGY_SCALE_RST;
      cutoff_r    <= aeh_pkg::ENERGY_CUTOFF_RST;
      esum_r      <= '0;
      count_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (sq_go || dv_go || cd_go) begin
        launched_r <= 1'b1;
      end else if (sq_done || dv_done || cd_done) begin
        launched_r <= 1'b0;
      end
      if (state_r == aeh_pkg::S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          aeh_pkg::CFG_ENERGY_SCALE:  scale_r  <= cfg_data;
          aeh_pkg::CFG_ENERGY_CUTOFF: cutoff_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (state_r == aeh_pkg::S_HWR) begin
        esum_r  <= aeh_pkg::sat_add(esum_r, contrib_r);
        count_r <= aeh_pkg::sat_add(count_r, 64'd1);
      end
    end
  end

  // shared multiplier, registered product
  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      aeh_pkg::S_IDLE: begin
        if (in_fire) begin
          op_r   <= in_ch.opcode;
          ux_r   <= in_ch.mom_x;
          uy_r   <= in_ch.mom_y;
          uz_r   <= in_ch.mom_z;
          w_r    <= in_ch.weight;
          rt_r   <= in_ch.read_theta;
          rp_r   <= in_ch.read_phi;
          bin_r  <= '0;
          ek_r   <= '0;
          tbin_r <= '0;
          pbin_r <= '0;
          acc_r  <= 1'b0;
        end
      end
      aeh_pkg::S_SQ_Y:   u2_r <= prod_r;
      aeh_pkg::S_SQ_Z:   u2_r <= u2_r + prod_r;
      aeh_pkg::S_SQ_ADD: u2_r <= u2_r + prod_r;
      aeh_pkg::S_ROOT1:  if (sq_done) d_r <= 64'h1_0000 + sq_root;
      aeh_pkg::S_DIV1:   if (dv_done) r_r <= dv_quo;
      aeh_pkg::S_EK_HI:  lo_r <= prod_r;
      aeh_pkg::S_EK_FIN: ek_r <= (ek_full[95:64] != 32'd0) ? aeh_pkg::E_MAX : ek_full[63:16];
      aeh_pkg::S_ROOT2:  if (sq_done) m_r <= sq_root[32:0];
      aeh_pkg::S_DIV2: begin
        if (dv_done) begin
          tbin_r <= (dv_quo >= 64'(THETA_BINS)) ? TW'(THETA_BINS - 1) : dv_quo[TW-1:0];
        end
      end
      aeh_pkg::S_ANGLE: begin
        if (cd_done) begin
          pbin_r <= (32'(pq) >= PHI_BINS) ? PW'(PHI_BINS - 1) : pq[PW-1:0];
        end
      end
      aeh_pkg::S_CW_HI:  lo_r <= prod_r;
      aeh_pkg::S_CW_FIN: contrib_r <= aeh_pkg::sat_add({prod_r[47:0], 16'd0},
                                                       {16'd0, lo_r[63:16]});
      aeh_pkg::S_HWR:    acc_r <= 1'b1;
      aeh_pkg::S_RCAP:   bin_r <= hrdata;
      default: begin
      end
    endcase
  end

  // result word register
  always_ff @(posedge clk) begin
    if (state_r == aeh_pkg::S_DONE && out_free) begin
      out_acc_r   <= acc_r;
      out_theta_r <= (op_r == aeh_pkg::OP_READ) ? rt_r : (acc_r ? 6'(tbin_r) : 6'd0);
      out_phi_r   <= (op_r == aeh_pkg::OP_READ) ? rp_r : (acc_r ? 6'(pbin_r) : 6'd0);
      out_ek_r    <= ek_r;
      out_bin_r   <= bin_r;
      out_esum_r  <= esum_r;
      out_count_r <= count_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.accepted       = out_acc_r;
  assign out_ch.theta_bin      = out_theta_r;
  assign out_ch.phi_bin        = out_phi_r;
  assign out_ch.kinetic_energy = out_ek_r;
  assign out_ch.bin_value      = out_bin_r;
  assign out_ch.total_energy   = out_esum_r;
  assign out_ch.total_count    = out_count_r;

endmodule
